// ===== sv/pbc_pkg.sv =====
`default_nettype none
package pbc_pkg;

   // Input beat actions.
   typedef enum logic [1:0] {
      ACT_LOAD_FIRST  = 2'd0,
      ACT_LOAD_SECOND = 2'd1,
      ACT_EVALUATE    = 2'd2,
      ACT_UNUSED      = 2'd3
   } action_type;

   // Result outcomes.
   typedef enum logic [1:0] {
      OUT_NONE    = 2'd0,
      OUT_OVERLAP = 2'd1,
      OUT_BOND    = 2'd2,
      OUT_SPARE   = 2'd3
   } outcome_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BOX_X       = 3'd0;
   localparam logic [2:0] CSR_BOX_Y       = 3'd1;
   localparam logic [2:0] CSR_BOX_Z       = 3'd2;
   localparam logic [2:0] CSR_CUT_SQ      = 3'd3;
   localparam logic [2:0] CSR_COS_MAX     = 3'd4;
   localparam logic [2:0] CSR_PATCH_COUNT = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;

   // Division runs one quotient bit per step over the 33-bit magnitude.
   localparam int DIV_STEPS  = 33;
   // Square root runs one result bit per step over a 48-bit radicand.
   localparam int SQRT_STEPS = 24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_INIT,
      ST_DIV,
      ST_WRAP,
      ST_SQ,
      ST_CHECK,
      ST_SQRT,
      ST_THR,
      ST_RD_A,
      ST_DOT_A,
      ST_TEST_A,
      ST_RD_B,
      ST_DOT_B,
      ST_TEST_B
   } state_type;

   typedef struct packed {
      logic [30:0] box_x;
      logic [30:0] box_y;
      logic [30:0] box_z;
      logic [30:0] cut_sq;
      logic [15:0] cos_max;
      logic [3:0]  patch_count;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_first;
      logic       load_second;
      logic       capture;
      logic       div_init;
      logic       div_step;
      logic       wrap;
      logic       sq_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       thr_load;
      logic       rd_en;
      logic       rd_second;
      logic       dot_clear;
      logic       dot_step;
      logic [1:0] axis;
      logic [1:0] comp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic overlap;
      logic in_cut;
      logic pass_first;
      logic pass_second;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/pbc_csr.sv =====
`default_nettype none
module pbc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [pbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [pbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output pbc_pkg::cfg_type                    cfg
);

   pbc_pkg::cfg_type cfg_ff, cfg_in;

   // Register write decode; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            pbc_pkg::CSR_BOX_X:       cfg_in.box_x = csr_wdata;
            pbc_pkg::CSR_BOX_Y:       cfg_in.box_y = csr_wdata;
            pbc_pkg::CSR_BOX_Z:       cfg_in.box_z = csr_wdata;
            pbc_pkg::CSR_CUT_SQ:      cfg_in.cut_sq = csr_wdata;
            pbc_pkg::CSR_COS_MAX:     cfg_in.cos_max = csr_wdata[15:0];
            pbc_pkg::CSR_PATCH_COUNT: cfg_in.patch_count = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_x       <= 31'd655360;
         cfg_ff.box_y       <= 31'd655360;
         cfg_ff.box_z       <= 31'd655360;
         cfg_ff.cut_sq      <= 31'd79299;
         cfg_ff.cos_max     <= 16'd14189;
         cfg_ff.patch_count <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/pbc_datapath.sv =====
`default_nettype none
module pbc_datapath #(
   parameter int MAX_PATCHES = 8,
   localparam int IDX_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1
) (
   input  wire logic                      clock,
   input  wire pbc_pkg::cfg_type          cfg,
   input  wire pbc_pkg::cmd_type          cmd,
   input  wire logic [IDX_W-1:0]          rd_idx,
   input  wire logic [2:0]                req_patch_slot,
   input  wire logic signed [31:0]        req_vec_x,
   input  wire logic signed [31:0]        req_vec_y,
   input  wire logic signed [31:0]        req_vec_z,
   input  wire logic signed [31:0]        req_other_x,
   input  wire logic signed [31:0]        req_other_y,
   input  wire logic signed [31:0]        req_other_z,
   output pbc_pkg::status_type            status
);

   // Patch stores, three Q1.14 components per entry.
   logic [47:0] first_store [MAX_PATCHES];
   logic [47:0] second_store [MAX_PATCHES];
   logic [47:0] entry_ff;

   logic signed [32:0] d_ff [3];
   logic signed [31:0] w_ff [3];
   logic [32:0]        a_ff, a_in;
   logic [30:0]        rem_ff, rem_in;
   logic               q_ff, q_in;
   logic               neg_ff;
   logic [62:0]        acc_ff;
   logic [47:0]        v_ff, v_in, res_ff, res_in, bit_ff;
   logic signed [40:0] thr_ff;
   logic signed [47:0] dot_ff;

   logic [4:0]         slot_ext;
   logic               slot_ok;
   logic [30:0]        box_raw;
   logic [31:0]        box32;
   logic [31:0]        t_val;
   logic               ge;
   logic [31:0]        twice;
   logic               round_up;
   logic signed [31:0] wmag;
   logic signed [31:0] w_new;
   logic signed [31:0] w_sel;
   logic signed [15:0] v_sel;
   logic signed [63:0] sq_prod;
   logic signed [47:0] dot_prod;
   logic [47:0]        root_sum;
   logic signed [48:0] thr49;
   logic signed [48:0] neg_dot;

   assign slot_ext = {2'b00, req_patch_slot};
   assign slot_ok  = slot_ext < 5'(MAX_PATCHES);

   // Store writes and registered entry read.
   always_ff @(posedge clock) begin
      if (cmd.load_first && slot_ok) begin
         first_store[slot_ext[IDX_W-1:0]] <=
            {req_vec_z[15:0], req_vec_y[15:0], req_vec_x[15:0]};
      end
      if (cmd.load_second && slot_ok) begin
         second_store[slot_ext[IDX_W-1:0]] <=
            {req_vec_z[15:0], req_vec_y[15:0], req_vec_x[15:0]};
      end
      if (cmd.rd_en) begin
         entry_ff <= cmd.rd_second ? second_store[rd_idx] : first_store[rd_idx];
      end
   end

   // Box of the current axis; a zero box acts as one LSB.
   always_comb begin
      case (cmd.axis)
         2'd0:    box_raw = cfg.box_x;
         2'd1:    box_raw = cfg.box_y;
         default: box_raw = cfg.box_z;
      endcase
      box32 = (box_raw == 31'd0) ? 32'd1 : {1'b0, box_raw};
   end

   // Restoring division step: one quotient bit, remainder stays below box.
   always_comb begin
      t_val  = {rem_ff, a_ff[32]};
      ge     = t_val >= box32;
      rem_in = ge ? 31'(t_val - box32) : t_val[30:0];
      a_in   = {a_ff[31:0], 1'b0};
      q_in   = ge;
   end

   // Round to nearest, ties to even, then restore the sign.
   always_comb begin
      twice    = {rem_ff, 1'b0};
      round_up = (twice > box32) || ((twice == box32) && q_ff);
      wmag     = round_up ? ($signed({1'b0, rem_ff}) - $signed(box32))
                          : $signed({1'b0, rem_ff});
      w_new    = neg_ff ? -wmag : wmag;
   end

   // Component selects for the shared multipliers.
   always_comb begin
      case (cmd.comp)
         2'd0:    w_sel = w_ff[0];
         2'd1:    w_sel = w_ff[1];
         default: w_sel = w_ff[2];
      endcase
      case (cmd.comp)
         2'd0:    v_sel = $signed(entry_ff[15:0]);
         2'd1:    v_sel = $signed(entry_ff[31:16]);
         default: v_sel = $signed(entry_ff[47:32]);
      endcase
      sq_prod  = w_sel * w_sel;
      dot_prod = 48'(w_sel * v_sel);
   end

   // Square root step, one result bit per cycle.
   always_comb begin
      root_sum = res_ff + bit_ff;
      if (v_ff >= root_sum) begin
         v_in   = v_ff - root_sum;
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         v_in   = v_ff;
         res_in = res_ff >> 1;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         d_ff[0] <= 33'(req_other_x) - 33'(req_vec_x);
         d_ff[1] <= 33'(req_other_y) - 33'(req_vec_y);
         d_ff[2] <= 33'(req_other_z) - 33'(req_vec_z);
         acc_ff  <= '0;
      end
      if (cmd.div_init) begin
         neg_ff <= d_ff[cmd.axis][32];
         a_ff   <= d_ff[cmd.axis][32] ? 33'(-d_ff[cmd.axis]) : d_ff[cmd.axis];
         rem_ff <= '0;
         q_ff   <= 1'b0;
      end
      if (cmd.div_step) begin
         a_ff   <= a_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
      if (cmd.wrap) begin
         w_ff[cmd.axis] <= w_new;
      end
      if (cmd.sq_step) begin
         acc_ff <= acc_ff + sq_prod[62:0];
      end
      if (cmd.sqrt_init) begin
         v_ff   <= acc_ff[47:0];
         res_ff <= '0;
         bit_ff <= 48'd1 << 46;
      end
      if (cmd.sqrt_step) begin
         v_ff   <= v_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.thr_load) begin
         thr_ff <= $signed(cfg.cos_max) * $signed({1'b0, res_ff[23:0]});
      end
      if (cmd.dot_clear) begin
         dot_ff <= '0;
      end
      if (cmd.dot_step) begin
         dot_ff <= dot_ff + dot_prod;
      end
   end

   // Status compares.
   always_comb begin
      thr49              = 49'(thr_ff);
      neg_dot            = -49'(dot_ff);
      status.overlap     = acc_ff[62:32] == 31'd0;
      status.in_cut      = acc_ff < {16'd0, cfg.cut_sq, 16'd0};
      status.pass_first  = 49'(dot_ff) > thr49;
      status.pass_second = neg_dot > thr49;
   end

endmodule
`default_nettype wire

// ===== sv/pbc_ctrl.sv =====
`default_nettype none
module pbc_ctrl #(
   parameter int MAX_PATCHES = 8,
   localparam int IDX_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_action,
   input  wire logic [3:0]           patch_count,
   input  wire pbc_pkg::status_type  status,
   output pbc_pkg::cmd_type          cmd,
   output logic [IDX_W-1:0]          rd_idx,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_outcome,
   output logic [2:0]                rsp_first_patch,
   output logic [2:0]                rsp_second_patch
);

   localparam int CNT_W = $clog2(MAX_PATCHES + 1);

   pbc_pkg::state_type state_ff, state_in;
   logic [5:0]       step_ff, step_in;
   logic [1:0]       axis_ff, axis_in;
   logic [1:0]       comp_ff, comp_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, count;
   logic             rv_ff, rv_in;
   logic [1:0]       ro_ff, ro_in;
   logic [2:0]       rf_ff, rf_in, rs_ff, rs_in;
   logic             last_i, last_j;

   assign count = ({1'b0, patch_count} > 5'(MAX_PATCHES)) ? CNT_W'(MAX_PATCHES)
                                                          : CNT_W'(patch_count);
   assign last_i = (i_ff + CNT_W'(1)) == count;
   assign last_j = (j_ff + CNT_W'(1)) == count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbc_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      step_ff <= step_in;
      axis_ff <= axis_in;
      comp_ff <= comp_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      ro_ff   <= ro_in;
      rf_ff   <= rf_in;
      rs_ff   <= rs_in;
   end

   // Next state, commands and result beat.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      comp_in  = comp_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rv_in    = 1'b0;
      ro_in    = ro_ff;
      rf_in    = rf_ff;
      rs_in    = rs_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      cmd.comp = comp_ff;
      rd_idx   = i_ff[IDX_W-1:0];
      case (state_ff)
         pbc_pkg::ST_IDLE: begin
            if (start) begin
               case (req_action)
                  pbc_pkg::ACT_LOAD_FIRST:  cmd.load_first = 1'b1;
                  pbc_pkg::ACT_LOAD_SECOND: cmd.load_second = 1'b1;
                  pbc_pkg::ACT_EVALUATE: begin
                     cmd.capture = 1'b1;
                     axis_in     = 2'd0;
                     state_in    = pbc_pkg::ST_DIV_INIT;
                  end
                  default: ;
               endcase
            end
         end
         pbc_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = pbc_pkg::ST_DIV;
         end
         pbc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'(pbc_pkg::DIV_STEPS - 1)) begin
               state_in = pbc_pkg::ST_WRAP;
            end
         end
         pbc_pkg::ST_WRAP: begin
            cmd.wrap = 1'b1;
            if (axis_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = pbc_pkg::ST_SQ;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = pbc_pkg::ST_DIV_INIT;
            end
         end
         pbc_pkg::ST_SQ: begin
            cmd.sq_step = 1'b1;
            comp_in     = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               state_in = pbc_pkg::ST_CHECK;
            end
         end
         pbc_pkg::ST_CHECK: begin
            rf_in = 3'd0;
            rs_in = 3'd0;
            if (status.overlap) begin
               rv_in    = 1'b1;
               ro_in    = pbc_pkg::OUT_OVERLAP;
               state_in = pbc_pkg::ST_IDLE;
            end else if (!status.in_cut || count == '0) begin
               rv_in    = 1'b1;
               ro_in    = pbc_pkg::OUT_NONE;
               state_in = pbc_pkg::ST_IDLE;
            end else begin
               cmd.sqrt_init = 1'b1;
               step_in       = '0;
               state_in      = pbc_pkg::ST_SQRT;
            end
         end
         pbc_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 6'd1;
            if (step_ff == 6'(pbc_pkg::SQRT_STEPS - 1)) begin
               state_in = pbc_pkg::ST_THR;
            end
         end
         pbc_pkg::ST_THR: begin
            cmd.thr_load = 1'b1;
            i_in         = '0;
            state_in     = pbc_pkg::ST_RD_A;
         end
         pbc_pkg::ST_RD_A: begin
            cmd.rd_en     = 1'b1;
            cmd.dot_clear = 1'b1;
            comp_in       = 2'd0;
            state_in      = pbc_pkg::ST_DOT_A;
         end
         pbc_pkg::ST_DOT_A: begin
            cmd.dot_step = 1'b1;
            comp_in      = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               state_in = pbc_pkg::ST_TEST_A;
            end
         end
         pbc_pkg::ST_TEST_A: begin
            if (status.pass_first) begin
               j_in     = '0;
               state_in = pbc_pkg::ST_RD_B;
            end else if (last_i) begin
               rv_in    = 1'b1;
               ro_in    = pbc_pkg::OUT_NONE;
               state_in = pbc_pkg::ST_IDLE;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = pbc_pkg::ST_RD_A;
            end
         end
         pbc_pkg::ST_RD_B: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_second = 1'b1;
            cmd.dot_clear = 1'b1;
            rd_idx        = j_ff[IDX_W-1:0];
            comp_in       = 2'd0;
            state_in      = pbc_pkg::ST_DOT_B;
         end
         pbc_pkg::ST_DOT_B: begin
            cmd.dot_step = 1'b1;
            comp_in      = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               state_in = pbc_pkg::ST_TEST_B;
            end
         end
         pbc_pkg::ST_TEST_B: begin
            if (status.pass_second) begin
               rv_in    = 1'b1;
               ro_in    = pbc_pkg::OUT_BOND;
               rf_in    = 3'(i_ff);
               rs_in    = 3'(j_ff);
               state_in = pbc_pkg::ST_IDLE;
            end else if (!last_j) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = pbc_pkg::ST_RD_B;
            end else if (last_i) begin
               rv_in    = 1'b1;
               ro_in    = pbc_pkg::OUT_NONE;
               state_in = pbc_pkg::ST_IDLE;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = pbc_pkg::ST_RD_A;
            end
         end
         default: state_in = pbc_pkg::ST_IDLE;
      endcase
   end

   assign busy             = state_ff != pbc_pkg::ST_IDLE;
   assign rsp_valid        = rv_ff;
   assign rsp_outcome      = ro_ff;
   assign rsp_first_patch  = rf_ff;
   assign rsp_second_patch = rs_ff;

endmodule
`default_nettype wire

// ===== sv/patchy_pair_bond_check.sv =====
// Patchy pair bond check. Load beats (action 0 or 1) write one patch vector
// into the first or second particle's store and are taken with no result.
// An evaluate beat (action 2) yields exactly one result beat on rsp_valid,
// held for a single cycle; the receiver cannot stall it, so it must take
// every strobe. Evaluation is serial: each axis is wrapped by a
// one-bit-per-cycle divider (division init, divide steps, wrap), then the
// squared distance is accumulated over the three components and the
// overlap/cutoff check follows, where an overlap or out-of-range pair
// answers. Inside the cutoff a square root and a threshold multiply follow,
// and each patch test then takes a store read, three multiply-accumulate
// steps and the compare, up to count*(count+1) tests. busy is high from
// the evaluate beat until its result strobe; start is taken only while busy
// is low. Patch stores hold garbage until written.
`default_nettype none
module patchy_pair_bond_check #(
   parameter int MAX_PATCHES = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_action,
   input  wire logic [2:0]                     req_patch_slot,
   input  wire logic signed [31:0]             req_vec_x,
   input  wire logic signed [31:0]             req_vec_y,
   input  wire logic signed [31:0]             req_vec_z,
   input  wire logic signed [31:0]             req_other_x,
   input  wire logic signed [31:0]             req_other_y,
   input  wire logic signed [31:0]             req_other_z,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_outcome,
   output logic [2:0]                          rsp_first_patch,
   output logic [2:0]                          rsp_second_patch,
   input  wire logic                           csr_we,
   input  wire logic [pbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [pbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;

   pbc_pkg::cfg_type    cfg;
   pbc_pkg::cmd_type    cmd;
   pbc_pkg::status_type status;
   logic [IDX_W-1:0]    rd_idx;

   pbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbc_ctrl #(.MAX_PATCHES(MAX_PATCHES)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_action       (req_action),
      .patch_count      (cfg.patch_count),
      .status           (status),
      .cmd              (cmd),
      .rd_idx           (rd_idx),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_outcome      (rsp_outcome),
      .rsp_first_patch  (rsp_first_patch),
      .rsp_second_patch (rsp_second_patch)
   );

   pbc_datapath #(.MAX_PATCHES(MAX_PATCHES)) u_dp (
      .clock          (clock),
      .cfg            (cfg),
      .cmd            (cmd),
      .rd_idx         (rd_idx),
      .req_patch_slot (req_patch_slot),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .req_other_x    (req_other_x),
      .req_other_y    (req_other_y),
      .req_other_z    (req_other_z),
      .status         (status)
   );

endmodule
`default_nettype wire

// ===== sv/pbc_checker.sv =====
`default_nettype none
module pbc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_outcome,
   input wire logic [2:0] rsp_first_patch,
   input wire logic [2:0] rsp_second_patch
);

   // A result beat never carries the spare outcome code.
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome != pbc_pkg::OUT_SPARE))
      else $error("result beat carries the spare outcome code");

   // Patch indexes are zero unless a bond is reported.
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != pbc_pkg::OUT_BOND) |->
         (rsp_first_patch == 3'd0 && rsp_second_patch == 3'd0))
      else $error("patch index set without a bond");

   // An accepted evaluate beat keeps the block busy in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == pbc_pkg::ACT_EVALUATE) |=> busy)
      else $error("evaluate beat did not start work");

   // Results are strobes of a single cycle.
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted two cycles");

   // A load beat taken while idle produces no result.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == pbc_pkg::ACT_LOAD_FIRST ||
                          req_action == pbc_pkg::ACT_LOAD_SECOND)) |=> !rsp_valid)
      else $error("load beat produced a result");

endmodule

bind patchy_pair_bond_check pbc_checker u_pbc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_outcome      (rsp_outcome),
   .rsp_first_patch  (rsp_first_patch),
   .rsp_second_patch (rsp_second_patch)
);
`default_nettype wire
